// File: design/rpsd_pkg.sv
// Package for the RGBW pixel string driver.
// Holds sizes, reset values, command codes, types and register indexes.
// No dependencies; used by rpsd_cfg_regs, rpsd_front, rpsd_queue, rpsd_back and the top level.
`timescale 1ns / 1ps

package rpsd_pkg;

  localparam int NUM_PIXELS     = 32;
  localparam int BITS_PER_PIXEL = 32;

  localparam int PIX_IDX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int BIT_IDX_W = 5;
  localparam int WORD_W    = 32;
  localparam int TIME_W    = 24;
  localparam int HL_W      = 10;
  localparam int LATCH_W   = 16;
  localparam int GAP_W     = 24;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BIT_IDX_W-1:0] BIT_LAST   = BIT_IDX_W'(BITS_PER_PIXEL - 1);
  localparam logic [BIT_IDX_W-1:0] BIT_OFFSET = BIT_IDX_W'(32 - BITS_PER_PIXEL);
  localparam logic [PIX_IDX_W:0]   PIX_COUNT  = (PIX_IDX_W + 1)'(NUM_PIXELS);
  localparam logic [WORD_W-1:0]    WORD_RESET = 32'h0100_0000;

  localparam logic [HL_W-1:0]    ONE_HIGH_RESET  = 10'd140;
  localparam logic [HL_W-1:0]    ONE_LOW_RESET   = 10'd120;
  localparam logic [HL_W-1:0]    ZERO_HIGH_RESET = 10'd70;
  localparam logic [HL_W-1:0]    ZERO_LOW_RESET  = 10'd160;
  localparam logic [LATCH_W-1:0] LATCH_RESET     = 16'd10200;
  localparam logic [GAP_W-1:0]   GAP_RESET       = 24'd4000000;

  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [2:0] REG_ONE_LOW   = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [2:0] REG_LATCH     = 3'd4;
  localparam logic [2:0] REG_GAP       = 3'd5;

  typedef enum logic [1:0] {
    KIND_SET,
    KIND_SEND,
    KIND_TICK,
    KIND_NOP
  } kind_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_HIGH  = 5'b00010,
    PH_LOW   = 5'b00100,
    PH_LATCH = 5'b01000,
    PH_WAIT  = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    LOAD_KEEP,
    LOAD_DEC,
    LOAD_HIGH,
    LOAD_LOW,
    LOAD_LATCH,
    LOAD_GAP,
    LOAD_ZERO
  } load_e;

  typedef struct packed {
    kind_e                kind;
    logic                 idx_ok;
    logic [PIX_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    word;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [HL_W-1:0]    one_high;
    logic [HL_W-1:0]    one_low;
    logic [HL_W-1:0]    zero_high;
    logic [HL_W-1:0]    zero_low;
    logic [LATCH_W-1:0] latch;
    logic [GAP_W-1:0]   gap;
  } cfg_t;

endpackage

// File: design/rpsd_in_if.sv
// Input channel of the RGBW pixel string driver: valid, ready and command payload.
// No dependencies; field widths are written out in the interface.
`timescale 1ns / 1ps

interface rpsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] white;

  modport source (
    output valid, cmd, pixel_index, red, green, blue, white,
    input  ready
  );

  modport sink (
    input  valid, cmd, pixel_index, red, green, blue, white,
    output ready
  );
endinterface

// File: design/rpsd_out_if.sv
// Result channel of the RGBW pixel string driver: valid, ready and result payload.
// No dependencies.
`timescale 1ns / 1ps

interface rpsd_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic accepted;

  modport source (
    output valid, pin_level, busy_res, accepted,
    input  ready
  );

  modport sink (
    input  valid, pin_level, busy_res, accepted,
    output ready
  );
endinterface

// File: design/rpsd_cfg_regs.sv
// APB-style register file for the segment timing of the pixel string driver.
// Depends on rpsd_pkg.
`timescale 1ns / 1ps

module rpsd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpsd_pkg::PADDR_W-1:0] paddr,
  input  logic [rpsd_pkg::PDATA_W-1:0] pwdata,
  output logic [rpsd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output rpsd_pkg::cfg_t              cfg_o
);

  rpsd_pkg::cfg_t cfg_q;
  rpsd_pkg::cfg_t cfg_d;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        rpsd_pkg::REG_ONE_HIGH:  cfg_d.one_high  = pwdata[rpsd_pkg::HL_W-1:0];
        rpsd_pkg::REG_ONE_LOW:   cfg_d.one_low   = pwdata[rpsd_pkg::HL_W-1:0];
        rpsd_pkg::REG_ZERO_HIGH: cfg_d.zero_high = pwdata[rpsd_pkg::HL_W-1:0];
        rpsd_pkg::REG_ZERO_LOW:  cfg_d.zero_low  = pwdata[rpsd_pkg::HL_W-1:0];
        rpsd_pkg::REG_LATCH:     cfg_d.latch     = pwdata[rpsd_pkg::LATCH_W-1:0];
        rpsd_pkg::REG_GAP:       cfg_d.gap       = pwdata[rpsd_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rpsd_pkg::REG_ONE_HIGH:  prdata = rpsd_pkg::PDATA_W'(cfg_q.one_high);
      rpsd_pkg::REG_ONE_LOW:   prdata = rpsd_pkg::PDATA_W'(cfg_q.one_low);
      rpsd_pkg::REG_ZERO_HIGH: prdata = rpsd_pkg::PDATA_W'(cfg_q.zero_high);
      rpsd_pkg::REG_ZERO_LOW:  prdata = rpsd_pkg::PDATA_W'(cfg_q.zero_low);
      rpsd_pkg::REG_LATCH:     prdata = rpsd_pkg::PDATA_W'(cfg_q.latch);
      rpsd_pkg::REG_GAP:       prdata = rpsd_pkg::PDATA_W'(cfg_q.gap);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high  <= rpsd_pkg::ONE_HIGH_RESET;
      cfg_q.one_low   <= rpsd_pkg::ONE_LOW_RESET;
      cfg_q.zero_high <= rpsd_pkg::ZERO_HIGH_RESET;
      cfg_q.zero_low  <= rpsd_pkg::ZERO_LOW_RESET;
      cfg_q.latch     <= rpsd_pkg::LATCH_RESET;
      cfg_q.gap       <= rpsd_pkg::GAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: design/rpsd_front.sv
// Front end of the pixel string driver: takes input transfers and classifies them.
// Depends on rpsd_pkg and rpsd_in_if; feeds rpsd_queue.
`timescale 1ns / 1ps

module rpsd_front (
  rpsd_in_if.sink          item_i,
  input  logic             full_i,
  output logic             push_o,
  output rpsd_pkg::item_t  item_o
);

  assign item_i.ready = ~full_i;
  assign push_o       = item_i.valid & ~full_i;

  always_comb begin
    unique case (item_i.cmd)
      rpsd_pkg::CMD_SET:  item_o.kind = rpsd_pkg::KIND_SET;
      rpsd_pkg::CMD_SEND: item_o.kind = rpsd_pkg::KIND_SEND;
      rpsd_pkg::CMD_TICK: item_o.kind = rpsd_pkg::KIND_TICK;
      default:            item_o.kind = rpsd_pkg::KIND_NOP;
    endcase
    item_o.idx_ok = {1'b0, item_i.pixel_index} < 9'(rpsd_pkg::NUM_PIXELS);
    item_o.idx    = item_i.pixel_index[rpsd_pkg::PIX_IDX_W-1:0];
    item_o.word   = {item_i.green, item_i.red, item_i.blue, item_i.white};
  end

endmodule

// File: design/rpsd_queue.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on rpsd_pkg.
`timescale 1ns / 1ps

module rpsd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rpsd_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output rpsd_pkg::head_t head_o
);

  rpsd_pkg::item_t entry_q [rpsd_pkg::QUEUE_DEPTH];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign full_o      = (count_q == 2'(rpsd_pkg::QUEUE_DEPTH));
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: design/rpsd_back.sv
// Back end of the pixel string driver: pixel store, waveform sequencer and result register.
// Depends on rpsd_pkg and rpsd_out_if; fed by rpsd_queue and rpsd_cfg_regs.
`timescale 1ns / 1ps

module rpsd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rpsd_pkg::head_t head_i,
  input  rpsd_pkg::cfg_t  cfg_i,
  output logic            pop_o,
  rpsd_out_if.source      result_o
);

  logic [rpsd_pkg::WORD_W-1:0]    store_q [rpsd_pkg::NUM_PIXELS];
  rpsd_pkg::phase_e               phase_q, phase_d;
  logic [rpsd_pkg::PIX_IDX_W-1:0] pc_q, pc_d;
  logic [rpsd_pkg::BIT_IDX_W-1:0] bc_q, bc_d;
  logic [rpsd_pkg::TIME_W-1:0]    tc_q, tc_d;
  logic                           line_q, line_d;
  logic                           out_valid_q;
  logic                           pin_q, pin_d;
  logic                           busy_q, busy_d;
  logic                           acc_q, acc_d;

  rpsd_pkg::load_e                load_sel;
  rpsd_pkg::item_t                item;
  logic                           idle;
  logic                           store_we;
  logic [rpsd_pkg::TIME_W-1:0]    tc_dec;
  logic [rpsd_pkg::BIT_IDX_W-1:0] bit_pos;
  logic                           cur_bit;
  logic [rpsd_pkg::HL_W-1:0]      high_ticks;
  logic [rpsd_pkg::HL_W-1:0]      low_ticks;

  function automatic logic [rpsd_pkg::TIME_W-1:0] at_least_one(
    input logic [rpsd_pkg::TIME_W-1:0] v
  );
    return (v == '0) ? rpsd_pkg::TIME_W'(1) : v;
  endfunction

  assign item   = head_i.item;
  assign pop_o  = head_i.valid & (~out_valid_q | result_o.ready);
  assign idle   = (phase_q == rpsd_pkg::PH_IDLE);
  assign tc_dec = (tc_q == '0) ? '0 : tc_q - rpsd_pkg::TIME_W'(1);

  always_comb begin
    phase_d  = phase_q;
    pc_d     = pc_q;
    bc_d     = bc_q;
    line_d   = line_q;
    load_sel = rpsd_pkg::LOAD_KEEP;
    store_we = 1'b0;
    acc_d    = 1'b0;
    unique case (item.kind)
      rpsd_pkg::KIND_TICK: begin
        if (!idle) begin
          load_sel = rpsd_pkg::LOAD_DEC;
          if (tc_dec == '0) begin
            unique case (phase_q)
              rpsd_pkg::PH_HIGH: begin
                phase_d  = rpsd_pkg::PH_LOW;
                line_d   = 1'b0;
                load_sel = rpsd_pkg::LOAD_LOW;
              end
              rpsd_pkg::PH_LOW: begin
                if (bc_q != '0) begin
                  bc_d     = bc_q - rpsd_pkg::BIT_IDX_W'(1);
                  phase_d  = rpsd_pkg::PH_HIGH;
                  line_d   = 1'b1;
                  load_sel = rpsd_pkg::LOAD_HIGH;
                end else if (({1'b0, pc_q} + (rpsd_pkg::PIX_IDX_W + 1)'(1))
                             < rpsd_pkg::PIX_COUNT) begin
                  pc_d     = pc_q + rpsd_pkg::PIX_IDX_W'(1);
                  bc_d     = rpsd_pkg::BIT_LAST;
                  phase_d  = rpsd_pkg::PH_HIGH;
                  line_d   = 1'b1;
                  load_sel = rpsd_pkg::LOAD_HIGH;
                end else begin
                  phase_d  = rpsd_pkg::PH_LATCH;
                  line_d   = 1'b0;
                  load_sel = rpsd_pkg::LOAD_LATCH;
                end
              end
              rpsd_pkg::PH_LATCH: begin
                line_d = 1'b0;
                if (cfg_i.gap == '0) begin
                  phase_d  = rpsd_pkg::PH_IDLE;
                  load_sel = rpsd_pkg::LOAD_ZERO;
                end else begin
                  phase_d  = rpsd_pkg::PH_WAIT;
                  load_sel = rpsd_pkg::LOAD_GAP;
                end
              end
              default: begin
                phase_d  = rpsd_pkg::PH_IDLE;
                line_d   = 1'b0;
                load_sel = rpsd_pkg::LOAD_ZERO;
              end
            endcase
          end
        end
      end
      rpsd_pkg::KIND_SET: begin
        if (idle && item.idx_ok) begin
          store_we = 1'b1;
          acc_d    = 1'b1;
        end
      end
      rpsd_pkg::KIND_SEND: begin
        if (idle) begin
          pc_d     = '0;
          bc_d     = rpsd_pkg::BIT_LAST;
          phase_d  = rpsd_pkg::PH_HIGH;
          line_d   = 1'b1;
          load_sel = rpsd_pkg::LOAD_HIGH;
          acc_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign bit_pos    = bc_d + rpsd_pkg::BIT_OFFSET;
  assign cur_bit    = store_q[pc_d][bit_pos];
  assign high_ticks = cur_bit ? cfg_i.one_high : cfg_i.zero_high;
  assign low_ticks  = cur_bit ? cfg_i.one_low : cfg_i.zero_low;

  always_comb begin
    unique case (load_sel)
      rpsd_pkg::LOAD_DEC:   tc_d = tc_dec;
      rpsd_pkg::LOAD_HIGH:  tc_d = at_least_one(rpsd_pkg::TIME_W'(high_ticks));
      rpsd_pkg::LOAD_LOW:   tc_d = at_least_one(rpsd_pkg::TIME_W'(low_ticks));
      rpsd_pkg::LOAD_LATCH: tc_d = at_least_one(rpsd_pkg::TIME_W'(cfg_i.latch));
      rpsd_pkg::LOAD_GAP:   tc_d = cfg_i.gap;
      rpsd_pkg::LOAD_ZERO:  tc_d = '0;
      default:              tc_d = tc_q;
    endcase
  end

  always_comb begin
    if (item.kind == rpsd_pkg::KIND_TICK) begin
      pin_d  = idle ? 1'b0 : line_q;
      busy_d = ~idle;
    end else begin
      pin_d  = line_d;
      busy_d = (phase_d != rpsd_pkg::PH_IDLE);
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.pin_level = pin_q;
  assign result_o.busy_res  = busy_q;
  assign result_o.accepted  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rpsd_pkg::NUM_PIXELS; i++) begin
        store_q[i] <= rpsd_pkg::WORD_RESET;
      end
    end else if (pop_o && store_we) begin
      store_q[item.idx] <= item.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rpsd_pkg::PH_IDLE;
      pc_q        <= '0;
      bc_q        <= rpsd_pkg::BIT_LAST;
      tc_q        <= '0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      pc_q        <= pc_d;
      bc_q        <= bc_d;
      tc_q        <= tc_d;
      line_q      <= line_d;
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pin_q  <= pin_d;
      busy_q <= busy_d;
      acc_q  <= acc_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_means_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rpsd_pkg::PH_IDLE) == (tc_q == '0))
    else $error("time counter disagrees with idle phase");

  a_line_high_only_in_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q == (phase_q == rpsd_pkg::PH_HIGH))
    else $error("line level disagrees with phase");

  a_send_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item.kind == rpsd_pkg::KIND_SEND && idle)
    |=> (phase_q == rpsd_pkg::PH_HIGH && result_o.accepted && result_o.valid))
    else $error("send while idle did not start a frame");

  a_busy_blocks_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !idle) |=> !result_o.accepted)
    else $error("command accepted while busy");
`endif

endmodule

// File: design/rgbw_pixel_string_driver_top.sv
// Top level of the RGBW pixel string driver.
// Instantiates rpsd_cfg_regs, rpsd_front, rpsd_queue and rpsd_back; uses rpsd_pkg,
// rpsd_in_if and rpsd_out_if.
//
// Channel    Direction  Form                 Contents
// item_i     in         valid/ready          cmd, pixel_index, red, green, blue, white
// result_o   out        valid/ready          pin_level, busy_res, accepted
// APB        in/out     psel/penable/pready  six timing registers at 4*i
//
// One item is taken every clock while the queue is not full; its result is registered.
// The back end sequencer sets the rate: one item per cycle unless the result stalls.
// A two-entry queue parts the input from the back end; a stalled result register
// holds and the queue absorbs up to two more items before item_i.ready drops.
// Reset is asynchronous and active low and sets every pixel word to 0x01000000.
`timescale 1ns / 1ps

module rgbw_pixel_string_driver_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rpsd_in_if.sink                      item_i,
  rpsd_out_if.source                   result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpsd_pkg::PADDR_W-1:0] paddr,
  input  logic [rpsd_pkg::PDATA_W-1:0] pwdata,
  output logic [rpsd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  rpsd_pkg::cfg_t  cfg;
  rpsd_pkg::item_t front_item;
  rpsd_pkg::head_t head;
  logic            push;
  logic            pop;
  logic            full;

  rpsd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rpsd_front u_front (
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  rpsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  rpsd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .cfg_i    (cfg),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule
